// File: rtl/oidl_pkg.sv
// ----------------------------------------------------------------------------
// oidl_pkg
// Shared types, sizes and codes for the ordered identifier list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oidl_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int ID_W        = 32;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int OUT_CNT_W   = 8;

  localparam logic       CMD_APPEND   = 1'b0;
  localparam logic       CMD_REMOVE   = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                   command;
    logic signed [ID_W-1:0] item_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] entry_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       ready;
    logic       load_in;
    logic       do_append;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_search;
    logic       rd_shift;
    logic       wr_shift;
    logic       dec_fill;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic match;
    logic idx_last;
    logic shift_end;
    logic out_free;
  } sts_t;

  // count as shown on the port, modulo 256
  function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, c};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: rtl/oidl_ram.sv
// ----------------------------------------------------------------------------
// oidl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/oidl_ctrl.sv
// ----------------------------------------------------------------------------
// oidl_ctrl
// Sequencer for append, search and shift-down of the identifier list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oidl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  oidl_pkg::sts_t sts,
  output oidl_pkg::ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RD     = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_SHRD   = 7'b0010000,
    S_SHWR   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (cmd_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_remove) begin
          ctl.set_status = 1'b1;
          if (sts.full) begin
            ctl.status_code = oidl_pkg::ST_FULL;
          end else begin
            ctl.status_code = oidl_pkg::ST_OK;
            ctl.do_append   = 1'b1;
          end
          state_next = S_FIN;
        end else if (sts.empty) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = oidl_pkg::ST_EMPTY;
          state_next      = S_FIN;
        end else begin
          ctl.idx_clr = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        ctl.rd_search = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          state_next = S_SHRD;
        end else if (sts.idx_last) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = oidl_pkg::ST_NOT_FOUND;
          state_next      = S_FIN;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_SHRD: begin
        // pull the next entry down, or close the list once past the tail
        if (sts.shift_end) begin
          ctl.dec_fill    = 1'b1;
          ctl.set_status  = 1'b1;
          ctl.status_code = oidl_pkg::ST_OK;
          state_next      = S_FIN;
        end else begin
          ctl.rd_shift = 1'b1;
          state_next   = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_next   = S_SHRD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/oidl_dp.sv
// ----------------------------------------------------------------------------
// oidl_dp
// Datapath: list store, fill count, scan index and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oidl_dp (
  input  logic           clk,
  input  logic           rst,
  input  oidl_pkg::cmd_t cmd,
  input  logic           rsp_stall,
  input  oidl_pkg::ctl_t ctl,
  output oidl_pkg::sts_t sts,
  output logic           rsp_valid,
  output oidl_pkg::rsp_t rsp
);

  logic                          cmd_r;
  logic [oidl_pkg::ID_W-1:0]     id_r;
  logic [oidl_pkg::CNT_W-1:0]    fill;
  logic [oidl_pkg::CNT_W-1:0]    idx;
  logic [oidl_pkg::CNT_W-1:0]    idx_p1;
  logic [1:0]                    status_r;
  logic [oidl_pkg::ID_W-1:0]     rd_data;
  logic                          ram_we;
  logic [oidl_pkg::ADDR_W-1:0]   ram_waddr;
  logic [oidl_pkg::ID_W-1:0]     ram_wdata;
  logic                          ram_re;
  logic [oidl_pkg::ADDR_W-1:0]   ram_raddr;

  assign idx_p1 = idx + oidl_pkg::CNT_W'(1);

  assign ram_we    = ctl.do_append | ctl.wr_shift;
  assign ram_waddr = ctl.do_append ? fill[oidl_pkg::ADDR_W-1:0] : idx[oidl_pkg::ADDR_W-1:0];
  assign ram_wdata = ctl.do_append ? id_r : rd_data;
  assign ram_re    = ctl.rd_search | ctl.rd_shift;
  assign ram_raddr = ctl.rd_shift ? idx_p1[oidl_pkg::ADDR_W-1:0] : idx[oidl_pkg::ADDR_W-1:0];

  oidl_ram #(
    .WIDTH (oidl_pkg::ID_W),
    .DEPTH (oidl_pkg::MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= cmd.command;
      id_r  <= cmd.item_id;
    end
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx_p1;
    end
    if (ctl.set_status) begin
      status_r <= ctl.status_code;
    end
    if (ctl.load_out) begin
      rsp.status      <= status_r;
      rsp.entry_count <= oidl_pkg::cnt_to_out(fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.do_append) begin
        fill <= fill + oidl_pkg::CNT_W'(1);
      end else if (ctl.dec_fill) begin
        fill <= fill - oidl_pkg::CNT_W'(1);
      end
      if (ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.is_remove = (cmd_r == oidl_pkg::CMD_REMOVE);
  assign sts.full      = (fill == oidl_pkg::CNT_W'(oidl_pkg::MAX_ENTRIES));
  assign sts.empty     = (fill == '0);
  assign sts.match     = (rd_data == id_r);
  assign sts.idx_last  = (idx_p1 == fill);
  assign sts.shift_end = (idx_p1 >= fill);
  assign sts.out_free  = !rsp_valid || !rsp_stall;

endmodule

// File: rtl/ordered_id_list_append_delete_unit.sv
// ----------------------------------------------------------------------------
// ordered_id_list_append_delete_unit
// Ordered identifier list: append at tail, remove first match from head.
// ----------------------------------------------------------------------------
//  port group   dir  word    handshake            contents
//  cmd          in   cmd_t   cmd_valid/cmd_stall  command, item_id
//  rsp          out  rsp_t   rsp_valid/rsp_stall  status, entry_count
//
//  One command at a time. Append and status-only commands pass through decode to
//  a loaded result register; a remove also scans the entries from the head, a
//  read and a compare for each, then on a match shifts each later entry down
//  with a read and a write through the RAM.
//  Reset (rst, synchronous) empties the list; the store itself is not cleared.
//  A new command is taken while a result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_id_list_append_delete_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  oidl_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output oidl_pkg::rsp_t rsp
);

  oidl_pkg::ctl_t ctl;
  oidl_pkg::sts_t sts;

  oidl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  oidl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign cmd_stall = !ctl.ready;

endmodule

// File: rtl/oidl_chk.sv
// ----------------------------------------------------------------------------
// oidl_chk
// Port-level checks for the ordered identifier list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oidl_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input oidl_pkg::rsp_t rsp
);

  // a result word stays up until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("rsp word dropped while stalled");

  // one command at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while busy");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == oidl_pkg::ST_FULL |->
      rsp.entry_count == oidl_pkg::OUT_CNT_W'(oidl_pkg::MAX_ENTRIES))
    else $error("full status with count below capacity");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == oidl_pkg::ST_EMPTY |-> rsp.entry_count == '0)
    else $error("empty status with nonzero count");

  a_nf_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == oidl_pkg::ST_NOT_FOUND && oidl_pkg::MAX_ENTRIES < 256
      |-> rsp.entry_count != '0)
    else $error("not-found status on an empty list");

endmodule

bind ordered_id_list_append_delete_unit oidl_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the ordered identifier list against a queue-based copy of the list.
// Every accepted command updates the copy and queues the status and entry
// count it must produce. Results are compared in order as they leave the
// block. Tests: edge identifiers and status codes, a full list, long random
// traffic with gaps and stalls, and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  oidl_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  oidl_pkg::rsp_t rsp;

  logic [oidl_pkg::ID_W-1:0] id_list[$];   // head at index 0
  oidl_pkg::rsp_t            due_rsp[$];   // results still owed by the block
  oidl_pkg::rsp_t            want;
  logic [oidl_pkg::ID_W-1:0] id_pool[8];   // small set of identifiers for duplicates
  int              err_count   = 0;
  int              hold_cycles = 0;
  int              burst_left  = 0;
  logic            gap_on      = 1'b0;
  rx_mode_e        rx_mode     = RX_FREE;

  ordered_id_list_append_delete_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (err_count < 50) begin
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, exp_val);
    end
    err_count++;
  endtask

  // Apply one accepted word to the list copy and queue its result.
  task automatic apply_to_list(input oidl_pkg::cmd_t w);
    oidl_pkg::rsp_t r;
    int   hit;
    hit = -1;
    if (w.command == oidl_pkg::CMD_APPEND) begin
      if (id_list.size() >= oidl_pkg::MAX_ENTRIES) begin
        r.status = oidl_pkg::ST_FULL;
      end else begin
        id_list.push_back(w.item_id);
        r.status = oidl_pkg::ST_OK;
      end
    end else if (id_list.size() == 0) begin
      r.status = oidl_pkg::ST_EMPTY;
    end else begin
      foreach (id_list[k]) begin
        if (hit < 0 && id_list[k] == w.item_id) hit = k;
      end
      if (hit < 0) begin
        r.status = oidl_pkg::ST_NOT_FOUND;
      end else begin
        id_list.delete(hit);
        r.status = oidl_pkg::ST_OK;
      end
    end
    r.entry_count = oidl_pkg::OUT_CNT_W'(id_list.size());
    due_rsp.push_back(r);
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so back-to-back words need no gap.
  task automatic send_word(input logic op, input logic [oidl_pkg::ID_W-1:0] ident);
    oidl_pkg::cmd_t w;
    w.command = op;
    w.item_id = ident;
    if (gap_on && burst_left == 0) begin
      cmd_valid = 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    cmd_valid = 1'b1;
    cmd = w;
    do @(posedge clk); while (cmd_stall);
    apply_to_list(w);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    cmd_valid = 1'b0;
    while (due_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: long hold-off first, otherwise the current stall pattern.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_stall = 1'b1;
        hold_cycles--;
      end else begin
        case (rx_mode)
          RX_FREE:  rsp_stall = 1'b0;
          RX_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
          default:  rsp_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsp.size() == 0) begin
        report_mismatch("unexpected result, status", int'(rsp.status), 0);
      end else begin
        want = due_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", int'(rsp.status), int'(want.status));
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", int'(rsp.entry_count), int'(want.entry_count));
      end
    end
  end

  task automatic test_edge_ids();
    rx_mode = RX_FREE;
    gap_on  = 1'b0;
    send_word(oidl_pkg::CMD_REMOVE, 32'h0000_0000);   // empty list
    send_word(oidl_pkg::CMD_REMOVE, 32'h8000_0000);
    send_word(oidl_pkg::CMD_APPEND, 32'h8000_0000);
    send_word(oidl_pkg::CMD_APPEND, 32'h7fff_ffff);
    send_word(oidl_pkg::CMD_APPEND, 32'h0000_0000);
    send_word(oidl_pkg::CMD_APPEND, 32'hffff_ffff);
    send_word(oidl_pkg::CMD_APPEND, 32'h7fff_ffff);   // duplicate
    send_word(oidl_pkg::CMD_REMOVE, 32'h0000_0001);   // no match
    send_word(oidl_pkg::CMD_REMOVE, 32'hffff_fffe);   // one bit off an entry
    send_word(oidl_pkg::CMD_REMOVE, 32'h7fff_ffff);   // first of the pair only
    send_word(oidl_pkg::CMD_REMOVE, 32'h7fff_ffff);
    send_word(oidl_pkg::CMD_REMOVE, 32'h7fff_ffff);   // both gone
    send_word(oidl_pkg::CMD_REMOVE, 32'h8000_0000);   // head
    send_word(oidl_pkg::CMD_REMOVE, 32'hffff_ffff);   // tail
    send_word(oidl_pkg::CMD_REMOVE, 32'h0000_0000);
    send_word(oidl_pkg::CMD_REMOVE, 32'h0000_0000);   // empty again
    send_word(oidl_pkg::CMD_APPEND, 32'h5a5a_5a5a);
    send_word(oidl_pkg::CMD_APPEND, 32'ha5a5_a5a5);
    send_word(oidl_pkg::CMD_REMOVE, 32'ha5a5_a5a5);
    send_word(oidl_pkg::CMD_REMOVE, 32'h5a5a_5a5a);
    wait_drained();
  endtask

  task automatic test_full_list();
    logic [oidl_pkg::ID_W-1:0] ident;
    rx_mode = RX_FREE;
    gap_on  = 1'b0;
    while (id_list.size() < oidl_pkg::MAX_ENTRIES) send_word(oidl_pkg::CMD_APPEND, $urandom);
    send_word(oidl_pkg::CMD_APPEND, 32'h8000_0000);   // full
    send_word(oidl_pkg::CMD_APPEND, 32'h7fff_ffff);
    send_word(oidl_pkg::CMD_REMOVE, ~id_list[0]);     // scan the whole list
    ident = id_list[oidl_pkg::MAX_ENTRIES-1];
    send_word(oidl_pkg::CMD_REMOVE, ident);           // match at the tail
    send_word(oidl_pkg::CMD_APPEND, ident);
    ident = id_list[0];
    send_word(oidl_pkg::CMD_REMOVE, ident);           // match at the head, shift all
    send_word(oidl_pkg::CMD_APPEND, ident);
    rx_mode = RX_LIGHT;
    gap_on  = 1'b1;
    while (id_list.size() > 0)
      send_word(oidl_pkg::CMD_REMOVE, id_list[$urandom_range(0, id_list.size() - 1)]);
    send_word(oidl_pkg::CMD_REMOVE, $urandom);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int                        append_pct;
    int                        pick;
    logic [oidl_pkg::ID_W-1:0] ident;
    append_pct = 60;
    for (int i = 0; i < n_items; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(0, 3))
          0:       append_pct = 85;
          1:       append_pct = 50;
          2:       append_pct = 30;
          default: append_pct = 60;
        endcase
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        gap_on  = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(1, 100) <= append_pct) begin
        if ($urandom_range(0, 9) < 4) ident = id_pool[$urandom_range(0, 7)];
        else ident = $urandom;
        send_word(oidl_pkg::CMD_APPEND, ident);
      end else begin
        pick = $urandom_range(0, 99);
        if (id_list.size() > 0 && pick < 70)
          ident = id_list[$urandom_range(0, id_list.size() - 1)];
        else if (id_list.size() > 0 && pick < 80)
          ident = id_list[$urandom_range(0, id_list.size() - 1)]
                  ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 90)
          ident = id_pool[$urandom_range(0, 7)];
        else
          ident = $urandom;
        send_word(oidl_pkg::CMD_REMOVE, ident);
      end
    end
    wait_drained();
  endtask

  // Hold the output long enough that the block backs up onto its input.
  task automatic test_output_hold();
    rx_mode     = RX_FREE;
    gap_on      = 1'b0;
    hold_cycles = 500;
    for (int i = 0; i < 40; i++)
      send_word((i % 5 == 4) ? oidl_pkg::CMD_REMOVE : oidl_pkg::CMD_APPEND, id_pool[i % 8]);
    wait_drained();
  endtask

  initial begin
    foreach (id_pool[k]) id_pool[k] = $urandom;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_edge_ids();
    test_full_list();
    test_random_traffic(600);
    test_output_hold();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("[ordered_id_list_append_delete_unit] OK");
    end else begin
      $display("[ordered_id_list_append_delete_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[ordered_id_list_append_delete_unit] ERROR");
    $finish;
  end

endmodule
